### design/wtg_pkg.sv
// Shared constants, types and table builders of the wavetable tone generator.
package wtg_pkg;

    // Block configuration
    localparam int SAMPLE_RATE = 44100;
    localparam int TABLE_SIZE  = 1024;
    localparam int FADE_MS     = 20;
    localparam int FULL_VOLUME = 1000;

    localparam int WAVE_PEAK = (1 << 15) - 1;
    localparam longint unsigned PI_E8   = 64'd314159265;
    localparam longint unsigned Q30_ONE = 64'd1 << 30;

    // Beat field widths
    localparam int FREQ_W   = 15;
    localparam int LEN_W    = 14;
    localparam int VOL_W    = 10;
    localparam int MODE_W   = 3;
    localparam int SAMPLE_W = 16;
    localparam int WORD_W   = 16;

    // Waveform codes
    localparam logic [MODE_W-1:0] MODE_SINE      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SINE_FADE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TRI       = 3'd2;
    localparam logic [MODE_W-1:0] MODE_TRI_FADE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DETUNE    = 3'd4;

    function automatic int max_int(int a, int b);
        return (a > b) ? a : b;
    endfunction

    // Greatest common divisor by repeated subtraction
    function automatic int gcd_sub(int a, int b);
        int x;
        int y;
        x = a;
        y = b;
        while (x != y) begin
            if (x > y) x = x - y;
            else       y = y - x;
        end
        return x;
    endfunction

    // Derived constants
    localparam int PH_W     = $clog2(TABLE_SIZE);
    localparam int HALF_TBL = TABLE_SIZE / 2;
    localparam int RATE_DIV = ((SAMPLE_RATE / TABLE_SIZE) > 0) ? (SAMPLE_RATE / TABLE_SIZE) : 1;
    localparam int LEN_GCD  = gcd_sub(SAMPLE_RATE, 1000);
    localparam int LEN_NUM  = SAMPLE_RATE / LEN_GCD;
    localparam int LEN_DEN  = 1000 / LEN_GCD;
    localparam int FADE_N   = FADE_MS * SAMPLE_RATE / 1000;
    localparam int TOT_W    =
        $clog2(longint'((1 << LEN_W) - 1) * SAMPLE_RATE / 1000 + 1);
    localparam int OFF_W    = $clog2(FADE_N + 1);

    // Widths of the serial divider lanes
    localparam int FPROD_W = VOL_W + WORD_W;
    localparam int LPROD_W = LEN_W + $clog2(LEN_NUM + 1);
    localparam int XPROD_W = OFF_W + VOL_W;
    localparam int DIV_W   = max_int(max_int(FPROD_W, LPROD_W), max_int(FREQ_W, XPROD_W));
    localparam int DVS_MAX = max_int(max_int(FULL_VOLUME, LEN_DEN), max_int(RATE_DIV, FADE_N));
    localparam int REM_W   = $clog2(DVS_MAX + 1);
    localparam int DCNT_W  = $clog2(DIV_W);

    // Lane assignment
    localparam int NUM_LANES  = 4;
    localparam int LANE_FRAME = 0;
    localparam int LANE_LEN   = 1;
    localparam int LANE_STEP  = 2;
    localparam int LANE_FADE  = 3;

    typedef struct packed {
        logic              start_req;
        logic [FREQ_W-1:0] freq_hz;
        logic [LEN_W-1:0]  length_ms;
        logic [VOL_W-1:0]  volume;
        logic [MODE_W-1:0] mode;
    } t_tone_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       active;
        logic                       last;
    } t_frame_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MULT,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef logic signed [WORD_W-1:0] t_rom [TABLE_SIZE];

    // Restoring division, elaboration only
    function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        int b;
        q = 0;
        r = 0;
        for (b = 63; b >= 0; b--) begin
            r = {r[62:0], n[b]};
            if (r >= d) begin
                r = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // r * pi / (2 * TABLE_SIZE) in Q30, truncated
    function automatic longint unsigned quad_angle(longint unsigned rr);
        longint unsigned num;
        longint unsigned den;
        longint unsigned res;
        longint unsigned rem;
        int b;
        num = rr * PI_E8;
        den = longint'(TABLE_SIZE) * 64'd200000000;
        res = udiv64(num, den);
        rem = num - res * den;
        for (b = 0; b < 30; b++) begin
            rem = rem << 1;
            res = res << 1;
            if (rem >= den) begin
                rem = rem - den;
                res = res | 64'd1;
            end
        end
        return res;
    endfunction

    // Q30 Taylor series: sine when odd, cosine otherwise
    function automatic longint unsigned trig_series(longint unsigned a, bit odd);
        longint unsigned a2;
        longint unsigned term;
        longint unsigned d;
        longint unsigned k;
        longint sum;
        a2   = (a * a) >> 30;
        term = odd ? a : Q30_ONE;
        sum  = 0;
        for (k = 1; k < 40 && term != 0; k++) begin
            if (k[0]) sum = sum + longint'(term);
            else      sum = sum - longint'(term);
            d    = odd ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k);
            term = udiv64((term * a2) >> 30, d);
        end
        if (sum < 0) sum = 0;
        if (sum > longint'(Q30_ONE)) sum = longint'(Q30_ONE);
        return longint'(sum);
    endfunction

    function automatic t_rom build_sine_rom();
        t_rom rom;
        longint unsigned four;
        longint unsigned quad;
        longint unsigned rr;
        longint unsigned s;
        longint unsigned v;
        int i;
        for (i = 0; i < TABLE_SIZE; i++) begin
            four = 64'(4 * i);
            quad = four / TABLE_SIZE;
            rr   = four - quad * TABLE_SIZE;
            s    = trig_series(quad_angle(rr), quad[0] == 1'b0);
            v    = longint'(WAVE_PEAK) * s;
            if (quad < 2) rom[i] = WORD_W'(v >> 30);
            else          rom[i] = WORD_W'(64'd0 - ((v + Q30_ONE - 64'd1) >> 30));
        end
        return rom;
    endfunction

    // Unipolar triangle, full scale at the midpoint
    function automatic t_rom build_tri_rom();
        t_rom rom;
        int i;
        for (i = 0; i < TABLE_SIZE; i++) begin
            if (i < HALF_TBL)          rom[i] = WORD_W'(longint'(WAVE_PEAK) * i / HALF_TBL);
            else if (i == HALF_TBL)    rom[i] = WORD_W'(WAVE_PEAK);
            else if (i < 2 * HALF_TBL) rom[i] = rom[2 * HALF_TBL - i];
            else                       rom[i] = '0;
        end
        return rom;
    endfunction

endpackage

### design/wtg_if.sv
// Valid/ready stream interfaces for tick requests and output frames.
interface wtg_tone_if;
    import wtg_pkg::*;

    logic     valid;
    logic     ready;
    t_tone_in payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface wtg_frame_if;
    import wtg_pkg::*;

    logic       valid;
    logic       ready;
    t_frame_out payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### design/wavetable_tone_generator_top.sv
// Wavetable tone generator: one tick beat in, one frame beat out, with a linear fade-out.
// Each tick beat yields exactly one frame beat. A tick steps through the states in order: ST_IDLE
// accepts the beat, ST_LOAD reads the wave table, ST_MULT forms the products, ST_DIV runs
// DIV_W steps of the bit-serial divider lanes and ST_FIN writes the frame. The four
// divider lanes (frame scaling, note length, phase step and fade ramp) run side by side,
// one quotient bit per cycle. A new tick is accepted while the previous
// frame still waits at the output; a tick only stalls there if that frame is still
// untaken when the next one is ready.
module wavetable_tone_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wtg_tone_if.sink    i_tone,
    wtg_frame_if.source o_frame
);
    import wtg_pkg::*;

    localparam t_rom SINE_ROM = build_sine_rom();
    localparam t_rom TRI_ROM  = build_tri_rom();

    t_state r_state, n_state;

    // Note state
    logic [PH_W-1:0]  r_phase_index;
    logic [PH_W-1:0]  r_phase_step;
    logic [TOT_W-1:0] r_sample_count;
    logic [TOT_W-1:0] r_total_samples;
    logic [TOT_W-1:0] r_fade_samples;
    logic [VOL_W-1:0] r_note_volume;
    logic [VOL_W-1:0] r_attenuation;
    logic             r_use_triangle;
    logic             r_playing;

    // Per-tick working registers
    t_tone_in                 r_req;
    logic signed [WORD_W-1:0] r_word;
    logic [VOL_W-1:0]         r_att_cur;
    logic                     r_tri_cur;
    logic                     r_upd;
    logic [OFF_W-1:0]         r_off;
    logic                     r_neg;
    logic [DCNT_W-1:0]        r_bit;
    logic [DIV_W-1:0]         r_dq  [NUM_LANES];
    logic [REM_W-1:0]         r_rem [NUM_LANES];
    logic [DIV_W-1:0]         n_dq  [NUM_LANES];
    logic [REM_W-1:0]         n_rem [NUM_LANES];

    t_frame_out r_out;
    logic       r_out_valid;

    // ---------------- load stage: pick the values this tick uses
    logic             start;
    logic             tri_ld;
    logic [PH_W-1:0]  phase_ld;
    logic [VOL_W-1:0] att_ld;
    logic [TOT_W-1:0] fade_thr;
    logic [TOT_W-1:0] off_full;
    logic             upd_ld;

    assign start    = r_req.start_req;
    assign tri_ld   = start ? (r_req.mode == MODE_TRI || r_req.mode == MODE_TRI_FADE)
                            : r_use_triangle;
    assign phase_ld = start ? '0 : r_phase_index;
    assign att_ld   = start ? r_req.volume : r_attenuation;
    assign fade_thr = r_total_samples - r_fade_samples;
    assign off_full = r_sample_count - fade_thr;
    assign upd_ld   = !start && r_playing && (r_fade_samples != '0)
                      && (r_sample_count > fade_thr);

    // ---------------- product stage
    logic signed [FPROD_W:0] frame_prod;
    logic [FPROD_W:0]        frame_abs;
    logic [LPROD_W-1:0]      len_prod;
    logic [XPROD_W-1:0]      fade_prod;

    assign frame_prod = $signed({1'b0, r_att_cur}) * r_word;
    assign frame_abs  = frame_prod[FPROD_W] ? (~frame_prod + 1'b1) : frame_prod;
    assign len_prod   = LPROD_W'(r_req.length_ms) * LPROD_W'(LEN_NUM);
    assign fade_prod  = XPROD_W'(r_off) * XPROD_W'(r_note_volume);

    // ---------------- divider lanes, one quotient bit per cycle
    logic [REM_W-1:0] dvs    [NUM_LANES];
    logic [REM_W:0]   div_sh [NUM_LANES];
    logic [REM_W:0]   div_df [NUM_LANES];

    assign dvs[LANE_FRAME] = REM_W'(FULL_VOLUME);
    assign dvs[LANE_LEN]   = REM_W'(LEN_DEN);
    assign dvs[LANE_STEP]  = REM_W'(RATE_DIV);
    assign dvs[LANE_FADE]  = REM_W'(r_fade_samples);

    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            div_sh[l] = {r_rem[l], r_dq[l][DIV_W-1]};
            div_df[l] = div_sh[l] - {1'b0, dvs[l]};
            if (div_sh[l] >= {1'b0, dvs[l]}) begin
                n_rem[l] = div_df[l][REM_W-1:0];
                n_dq[l]  = {r_dq[l][DIV_W-2:0], 1'b1};
            end else begin
                n_rem[l] = div_sh[l][REM_W-1:0];
                n_dq[l]  = {r_dq[l][DIV_W-2:0], 1'b0};
            end
        end
    end

    // ---------------- finish stage: frame value and note state update
    logic [DIV_W-1:0]    q_frame;
    logic [DIV_W-1:0]    q_len;
    logic [DIV_W-1:0]    q_step;
    logic [DIV_W-1:0]    q_drop;
    logic [TOT_W-1:0]    tot_fn;
    logic [TOT_W-1:0]    fade_fn;
    logic [TOT_W-1:0]    k_fn;
    logic [TOT_W:0]      k_inc;
    logic                play_fn;
    logic                fin_fn;
    logic [PH_W-1:0]     step_fn;
    logic [PH_W-1:0]     phase_fn;
    logic [VOL_W-1:0]    vol_fn;
    logic [VOL_W-1:0]    att_fn;
    logic [SAMPLE_W-1:0] mag16;
    logic [SAMPLE_W-1:0] sample_fn;
    logic                out_go;

    assign q_frame  = r_dq[LANE_FRAME];
    assign q_len    = r_dq[LANE_LEN];
    assign q_step   = r_dq[LANE_STEP];
    assign q_drop   = r_dq[LANE_FADE];

    assign tot_fn   = start ? q_len[TOT_W-1:0] : r_total_samples;
    assign fade_fn  = (tot_fn < TOT_W'(FADE_N)) ? tot_fn : TOT_W'(FADE_N);
    assign play_fn  = start ? (q_len[TOT_W-1:0] != '0) : r_playing;
    assign k_fn     = start ? '0 : r_sample_count;
    assign k_inc    = {1'b0, k_fn} + 1'b1;
    assign fin_fn   = (k_inc >= {1'b0, tot_fn});
    // table size is a power of two, so the low bits give the step modulo the table
    assign step_fn  = start ? q_step[PH_W-1:0] : r_phase_step;
    assign phase_fn = start ? '0 : r_phase_index;
    assign vol_fn   = start ? r_req.volume : r_note_volume;
    assign mag16    = q_frame[SAMPLE_W-1:0];
    assign out_go   = !r_out_valid || o_frame.ready;

    always_comb begin
        if (r_upd) begin
            att_fn = (q_drop > DIV_W'(vol_fn)) ? '0 : (vol_fn - q_drop[VOL_W-1:0]);
        end else begin
            att_fn = start ? r_req.volume : r_attenuation;
        end
    end

    // Truncated quotient, signed and saturated to 16 bits
    always_comb begin
        if (!play_fn) begin
            sample_fn = '0;
        end else if (!r_neg) begin
            sample_fn = (q_frame > DIV_W'(WAVE_PEAK)) ? SAMPLE_W'(WAVE_PEAK) : mag16;
        end else begin
            sample_fn = (q_frame > DIV_W'(WAVE_PEAK + 1)) ? SAMPLE_W'(WAVE_PEAK + 1)
                                                         : (SAMPLE_W'(0) - mag16);
        end
    end

    // ---------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_tone.valid) n_state = ST_LOAD;
            end
            ST_LOAD: n_state = ST_MULT;
            ST_MULT: n_state = ST_DIV;
            ST_DIV: begin
                if (r_bit == DCNT_W'(DIV_W - 1)) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_go) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- port outputs
    always_comb begin
        i_tone.ready    = (r_state == ST_IDLE);
        o_frame.valid   = r_out_valid;
        o_frame.payload = r_out;
    end

    // ---------------- control and note state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_out_valid     <= 1'b0;
            r_phase_index   <= '0;
            r_phase_step    <= '0;
            r_sample_count  <= '0;
            r_total_samples <= '0;
            r_fade_samples  <= '0;
            r_note_volume   <= '0;
            r_attenuation   <= '0;
            r_use_triangle  <= 1'b0;
            r_playing       <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_state == ST_FIN && out_go) begin
                r_out_valid <= 1'b1;
            end else if (o_frame.ready) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == ST_FIN && out_go) begin
                if (start) begin
                    r_total_samples <= tot_fn;
                    r_fade_samples  <= fade_fn;
                    r_note_volume   <= vol_fn;
                    r_phase_step    <= step_fn;
                    r_use_triangle  <= r_tri_cur;
                end
                r_phase_index  <= play_fn ? (phase_fn + step_fn) : phase_fn;
                r_sample_count <= play_fn ? k_inc[TOT_W-1:0] : k_fn;
                r_attenuation  <= att_fn;
                r_playing      <= play_fn && !fin_fn;
            end
        end
    end

    // ---------------- datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_tone.valid) begin
            r_req <= i_tone.payload;
        end

        if (r_state == ST_LOAD) begin
            r_word    <= tri_ld ? TRI_ROM[phase_ld] : SINE_ROM[phase_ld];
            r_att_cur <= att_ld;
            r_tri_cur <= tri_ld;
            r_upd     <= upd_ld;
            r_off     <= off_full[OFF_W-1:0];
        end

        if (r_state == ST_MULT) begin
            r_neg             <= frame_prod[FPROD_W];
            r_bit             <= '0;
            r_dq[LANE_FRAME]  <= DIV_W'(frame_abs[FPROD_W-1:0]);
            r_dq[LANE_LEN]    <= DIV_W'(len_prod);
            r_dq[LANE_STEP]   <= DIV_W'(r_req.freq_hz);
            r_dq[LANE_FADE]   <= DIV_W'(fade_prod);
            for (int l = 0; l < NUM_LANES; l++) begin
                r_rem[l] <= '0;
            end
        end else if (r_state == ST_DIV) begin
            r_bit <= r_bit + 1'b1;
            for (int l = 0; l < NUM_LANES; l++) begin
                r_dq[l]  <= n_dq[l];
                r_rem[l] <= n_rem[l];
            end
        end

        if (r_state == ST_FIN && out_go) begin
            r_out.sample <= $signed(sample_fn);
            r_out.active <= play_fn;
            r_out.last   <= play_fn && fin_fn;
        end
    end

    // ---------------- checks
    a_idle_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame.valid && !o_frame.payload.active
            |-> o_frame.payload.sample == '0 && !o_frame.payload.last)
        else $error("idle frame carries data");

    a_att_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_playing |-> r_attenuation <= r_note_volume)
        else $error("attenuation above note volume");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_playing |-> r_sample_count < r_total_samples)
        else $error("frame count past note length");

    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && out_go && play_fn && fin_fn) |=> !r_playing)
        else $error("note still playing after last frame");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_rem[LANE_FRAME] < REM_W'(FULL_VOLUME))
        else $error("frame divider remainder out of range");

endmodule

### tb/testbench.sv
// Self-checking testbench for the wavetable tone generator: directed notes, then random phrases.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wtg_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_TICKS = 650;
    localparam int WATCHDOG_MAX = 4000;
    localparam int TAIL_CYCLES  = 64;
    localparam int LONG_HOLD    = 400;
    localparam int MAX_PRINTS   = 40;
    localparam int FOLLOW_CAP   = 140;
    localparam int DRAIN_EVERY  = 300;
    localparam int CNT_W        = 20;

    // Waveform codes without a name in the block; both fall back to the sine
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam int FADE_FRAMES = FADE_MS * SAMPLE_RATE / 1000;
    localparam int PHASE_DIV   = (SAMPLE_RATE / TABLE_SIZE > 0) ? SAMPLE_RATE / TABLE_SIZE : 1;
    localparam int SAT_HI      = (1 << (SAMPLE_W - 1)) - 1;
    localparam int SAT_LO      = -(1 << (SAMPLE_W - 1));

    typedef struct {
        t_tone_in   tick;
        bit         typed;
        t_frame_out want;
        int         follow;
    } t_tone_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wtg_tone_if  tone_bus ();
    wtg_frame_if frame_bus ();

    wavetable_tone_generator_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tone  (tone_bus),
        .o_frame (frame_bus)
    );

    // 8 ns clock
    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Oscillator model state
    int               sine_wave [TABLE_SIZE];
    int               tri_wave  [TABLE_SIZE];
    logic [PH_W-1:0]  osc_phase;
    logic [PH_W-1:0]  osc_inc;
    logic [CNT_W-1:0] note_pos;
    logic [CNT_W-1:0] note_frames;
    logic [CNT_W-1:0] ramp_frames;
    logic [VOL_W-1:0] note_gain;
    logic [VOL_W-1:0] cur_gain;
    logic             tri_sel;
    logic             note_on;

    t_frame_out pending_frames [$];
    t_tone_row  directed_rows [$];
    t_frame_out head_frame;
    int         mismatches  = 0;
    int         frames_seen = 0;
    int         ticks_sent  = 0;
    int         idle_cycles = 0;

    // Angle r * pi / (2 * TABLE_SIZE) as a truncated Q30 value
    function automatic longint unsigned angle_q30(int r);
        logic [95:0] num;
        logic [95:0] den;
        num = 96'(r) * 96'd314159265;
        den = 96'(TABLE_SIZE) * 96'd200000000;
        return 64'((num << 30) / den);
    endfunction

    // Q30 Taylor sum: odd powers give the sine, even powers the cosine
    function automatic longint unsigned series_q30(longint unsigned x, bit odd_terms);
        longint unsigned sq;
        longint unsigned term;
        longint unsigned div;
        longint          acc;
        int              n;
        sq   = (x * x) >> 30;
        term = odd_terms ? x : Q30_ONE;
        acc  = 0;
        for (n = 1; n < 40 && term != 0; n++) begin
            if (n % 2 == 1) acc = acc + longint'(term);
            else            acc = acc - longint'(term);
            div  = odd_terms ? 64'(2 * n) * 64'(2 * n + 1) : 64'(2 * n - 1) * 64'(2 * n);
            term = ((term * sq) >> 30) / div;
        end
        if (acc < 0) acc = 0;
        if (acc > longint'(Q30_ONE)) acc = longint'(Q30_ONE);
        return 64'(acc);
    endfunction

    // Fill both wave tables; lower half of the sine rounds down, upper half rounds away
    function automatic void build_wave_roms();
        longint unsigned s;
        longint unsigned v;
        int quad;
        int rr;
        int i;
        int half;
        half = TABLE_SIZE / 2;
        for (i = 0; i < TABLE_SIZE; i++) begin
            quad = (4 * i) / TABLE_SIZE;
            rr   = 4 * i - quad * TABLE_SIZE;
            s    = series_q30(angle_q30(rr), quad % 2 == 0);
            v    = 64'(WAVE_PEAK) * s;
            if (quad < 2) sine_wave[i] = int'(v >> 30);
            else          sine_wave[i] = -int'((v + Q30_ONE - 64'd1) >> 30);
        end
        for (i = 0; i < TABLE_SIZE; i++) begin
            if (i < half)          tri_wave[i] = int'(longint'(WAVE_PEAK) * i / half);
            else if (i == half)    tri_wave[i] = WAVE_PEAK;
            else if (i < 2 * half) tri_wave[i] = tri_wave[2 * half - i];
            else                   tri_wave[i] = 0;
        end
    endfunction

    // One tick of the oscillator: optional note load, then the frame it yields
    function automatic t_frame_out synth_frame(t_tone_in t);
        t_frame_out f;
        longint     frames;
        longint     ramp;
        longint     off;
        longint     drop;
        int         word;
        int         val;
        int         k;
        f = '0;
        if (t.start_req) begin
            frames      = longint'(t.length_ms) * SAMPLE_RATE / 1000;
            ramp        = (FADE_FRAMES < frames) ? FADE_FRAMES : frames;
            note_gain   = t.volume;
            cur_gain    = t.volume;
            note_frames = CNT_W'(frames);
            ramp_frames = CNT_W'(ramp);
            osc_inc     = PH_W'((int'(t.freq_hz) / PHASE_DIV) % TABLE_SIZE);
            osc_phase   = '0;
            note_pos    = '0;
            tri_sel     = (t.mode == MODE_TRI) || (t.mode == MODE_TRI_FADE);
            note_on     = (frames != 0);
        end
        if (!note_on) return f;

        word = tri_sel ? tri_wave[osc_phase] : sine_wave[osc_phase];
        val  = int'(cur_gain) * word / FULL_VOLUME;
        if (val > SAT_HI) val = SAT_HI;
        if (val < SAT_LO) val = SAT_LO;

        k        = int'(note_pos);
        f.sample = SAMPLE_W'(val);
        f.active = 1'b1;
        f.last   = (k + 1 >= int'(note_frames));

        osc_phase = PH_W'((int'(osc_phase) + int'(osc_inc)) % TABLE_SIZE);

        // linear ramp down over the closing window
        if (ramp_frames != 0 && k > int'(note_frames) - int'(ramp_frames)) begin
            off      = longint'(k) - (longint'(note_frames) - longint'(ramp_frames));
            drop     = off * longint'(note_gain) / longint'(ramp_frames);
            cur_gain = (drop > longint'(note_gain)) ? '0 :
                       VOL_W'(longint'(note_gain) - drop);
        end
        note_pos = CNT_W'(k + 1);
        if (f.last) note_on = 1'b0;
        return f;
    endfunction

    function automatic t_tone_in rand_tick(bit go);
        t_tone_in t;
        t.start_req = go;
        t.freq_hz   = FREQ_W'($urandom);
        t.length_ms = LEN_W'($urandom);
        t.volume    = VOL_W'($urandom);
        t.mode      = MODE_W'($urandom);
        return t;
    endfunction

    // Sender gap; one window in five runs back to back
    function automatic int pick_gap();
        int r;
        if ((ticks_sent / 128) % 5 == 2) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS) $display("%0t ns: %s", $time, what);
    endtask

    // Offer one tick beat and log the frame it must produce
    task automatic send_tick(input t_tone_in t, input bit typed, input t_frame_out want);
        int         gap;
        t_frame_out predicted;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            tone_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tone_bus.valid   <= 1'b1;
        tone_bus.payload <= t;
        do @(posedge i_clk); while (tone_bus.ready !== 1'b1);
        ticks_sent++;
        predicted = synth_frame(t);
        pending_frames.push_back(typed ? want : predicted);
    endtask

    // Stop offering until every logged frame has come back
    task automatic wait_drained();
        @(negedge i_clk);
        tone_bus.valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
    endtask

    function automatic void add_row(bit go, int freq, int len, int vol,
                                    logic [MODE_W-1:0] md, bit typed,
                                    int smp, bit act, bit fin, int follow);
        t_tone_row row;
        row.tick.start_req = go;
        row.tick.freq_hz   = FREQ_W'(freq);
        row.tick.length_ms = LEN_W'(len);
        row.tick.volume    = VOL_W'(vol);
        row.tick.mode      = md;
        row.typed          = typed;
        row.want.sample    = SAMPLE_W'(smp);
        row.want.active    = act;
        row.want.last      = fin;
        row.follow         = follow;
        directed_rows.push_back(row);
    endfunction

    task automatic run_directed();
        int i;
        // idle right after reset, every field but the start flag high
        add_row(1'b0, 32767, 16383, 1023, MODE_SPARE_HI, 1'b1, 0, 1'b0, 1'b0, 0);
        // zero-length note plays nothing
        add_row(1'b1, 32767, 0, 1023, MODE_SINE, 1'b1, 0, 1'b0, 1'b0, 1);
        // short notes played out; the first frame always sits at phase zero
        add_row(1'b1, 440, 1, 1000, MODE_SINE, 1'b1, 0, 1'b1, 1'b0, 44);
        add_row(1'b1, 1000, 2, 1000, MODE_TRI, 1'b1, 0, 1'b1, 1'b0, 88);
        // gain above full scale: frames clip at both rails
        add_row(1'b1, 20000, 1, 1023, MODE_SINE_FADE, 1'b1, 0, 1'b1, 1'b0, 44);
        add_row(1'b1, 22050, 1, 1023, MODE_TRI_FADE, 1'b1, 0, 1'b1, 1'b0, 44);
        add_row(1'b1, 11025, 21, 1023, MODE_SINE_FADE, 1'b1, 0, 1'b1, 1'b0, 8);
        // detune plays the plain sine; replaces the running note
        add_row(1'b1, 32767, 3, 500, MODE_DETUNE, 1'b1, 0, 1'b1, 1'b0, 20);
        // new note at zero volume cuts in
        add_row(1'b1, 43, 1, 0, MODE_SINE, 1'b1, 0, 1'b1, 1'b0, 10);
        // zero-length start stops the running note
        add_row(1'b1, 5000, 0, 700, MODE_TRI, 1'b1, 0, 1'b0, 1'b0, 2);
        // spare codes fall back to the sine
        add_row(1'b1, 5000, 1, 1000, MODE_SPARE_LO, 1'b1, 0, 1'b1, 1'b0, 44);
        add_row(1'b1, 7000, 1, 900, MODE_SPARE_HI, 1'b1, 0, 1'b1, 1'b0, 10);
        // zero phase increment
        add_row(1'b1, 0, 1, 1000, MODE_SINE, 1'b1, 0, 1'b1, 1'b0, 44);
        // longest note, cut short by the next one
        add_row(1'b1, 440, 16383, 1000, MODE_SINE, 1'b1, 0, 1'b1, 1'b0, 30);
        // flat run, then well into the fade
        add_row(1'b1, 3000, 21, 800, MODE_TRI, 1'b1, 0, 1'b1, 1'b0, 100);
        // zero-length start ends the fading note
        add_row(1'b1, 0, 0, 0, MODE_SINE, 1'b1, 0, 1'b0, 1'b0, 0);

        for (i = 0; i < directed_rows.size(); i++) begin
            send_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].want);
            repeat (directed_rows[i].follow) send_tick(rand_tick(1'b0), 1'b0, '0);
        end
        wait_drained();
    endtask

    // Mostly whole notes with random content, some cut short, some loose noise
    task automatic run_random();
        t_tone_in t;
        int sent;
        int next_drain;
        int total;
        int follow;
        int r;
        int n;
        sent       = 0;
        next_drain = DRAIN_EVERY;
        while (sent < RANDOM_TICKS) begin
            if (sent >= next_drain) begin
                wait_drained();
                next_drain = next_drain + DRAIN_EVERY;
            end
            r = $urandom_range(0, 99);
            if (r < 10) begin
                n = $urandom_range(1, 8);
                repeat (n) begin
                    send_tick(rand_tick($urandom_range(0, 3) == 0), 1'b0, '0);
                    sent++;
                end
            end else begin
                t = rand_tick(1'b1);
                r = $urandom_range(0, 99);
                if (r < 8)       t.length_ms = '0;
                else if (r < 75) t.length_ms = LEN_W'($urandom_range(1, 3));
                else if (r < 90) t.length_ms = LEN_W'($urandom_range(4, 30));
                if ($urandom_range(0, 1) == 1) t.freq_hz = FREQ_W'($urandom_range(0, 20000));
                case ($urandom_range(0, 8))
                    0:       t.volume = '0;
                    1:       t.volume = VOL_W'(FULL_VOLUME);
                    2:       t.volume = '1;
                    default: ;
                endcase
                send_tick(t, 1'b0, '0);
                sent++;
                total = int'(t.length_ms) * SAMPLE_RATE / 1000;
                if (total <= FOLLOW_CAP && $urandom_range(0, 4) != 0)
                    follow = ((total > 0) ? total - 1 : 0) + $urandom_range(0, 3);
                else
                    follow = $urandom_range(0, (total < FOLLOW_CAP) ? total : FOLLOW_CAP);
                repeat (follow) begin
                    send_tick(rand_tick(1'b0), 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    // Frame sink: random stalls, calm windows, and a long hold now and then
    initial begin
        int hold_left;
        int next_long_hold;
        int r;
        frame_bus.ready = 1'b0;
        hold_left       = 0;
        next_long_hold  = 150;
        forever begin
            @(negedge i_clk);
            if (hold_left == 0 && frames_seen >= next_long_hold) begin
                hold_left      = LONG_HOLD;
                next_long_hold = next_long_hold + 1200;
            end
            if (hold_left > 0) begin
                hold_left--;
                frame_bus.ready <= 1'b0;
            end else if ((frames_seen / 128) % 5 == 4) begin
                frame_bus.ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 65) begin
                    frame_bus.ready <= 1'b1;
                end else begin
                    if (r < 92)      hold_left = $urandom_range(1, 3) - 1;
                    else if (r < 98) hold_left = $urandom_range(4, 15) - 1;
                    else             hold_left = $urandom_range(20, 60) - 1;
                    frame_bus.ready <= 1'b0;
                end
            end
        end
    end

    // Compare each frame beat with the oldest logged frame
    always @(posedge i_clk) begin
        if (frame_bus.valid === 1'b1 && frame_bus.ready === 1'b1) begin
            frames_seen++;
            if (pending_frames.size() == 0) begin
                report_mismatch($sformatf("frame beat %0d with nothing expected", frames_seen));
            end else begin
                head_frame = pending_frames.pop_front();
                if (frame_bus.payload.sample !== head_frame.sample)
                    report_mismatch($sformatf("frame %0d sample got %0d want %0d", frames_seen,
                                              frame_bus.payload.sample, head_frame.sample));
                if (frame_bus.payload.active !== head_frame.active)
                    report_mismatch($sformatf("frame %0d active got %b want %b", frames_seen,
                                              frame_bus.payload.active, head_frame.active));
                if (frame_bus.payload.last !== head_frame.last)
                    report_mismatch($sformatf("frame %0d last got %b want %b", frames_seen,
                                              frame_bus.payload.last, head_frame.last));
            end
        end
    end

    // Watchdog: cycles in a row without any beat
    initial begin
        while (idle_cycles < WATCHDOG_MAX) begin
            @(posedge i_clk);
            if ((tone_bus.valid === 1'b1 && tone_bus.ready === 1'b1) ||
                (frame_bus.valid === 1'b1 && frame_bus.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Reset, stimulus, drain and verdict
    initial begin
        i_rst_n          = 1'b0;
        tone_bus.valid   = 1'b0;
        tone_bus.payload = '0;
        osc_phase        = '0;
        osc_inc          = '0;
        note_pos         = '0;
        note_frames      = '0;
        ramp_frames      = '0;
        note_gain        = '0;
        cur_gain         = '0;
        tri_sel          = 1'b0;
        note_on          = 1'b0;
        build_wave_roms();
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        run_random();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_frames.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### wavetable_tone_generator_top.f
design/wtg_pkg.sv
design/wtg_if.sv
design/wavetable_tone_generator_top.sv
tb/testbench.sv
